// File: src/brb_pkg.sv
`timescale 1ns / 1ps
// brb_pkg: shared types and field widths for the byte ring buffer.
// Used by brb_front, brb_back and byte_ring_buffer; depends on nothing.
package brb_pkg;

    localparam int BYTE_W = 8;
    localparam int OFF_W  = 11;
    localparam int LEN_W  = 11;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        OP_PUT     = 2'd0,
        OP_REPLACE = 2'd1,
        OP_BURST   = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

    // Classified command handed from the front to the back
    typedef struct packed {
        t_op                      op;
        logic [BYTE_W-1:0]        data;
        logic signed [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]         length;
        logic [CNT_W-1:0]         read_len;
        logic                     first;
    } t_cmd;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] read_byte;
        logic              byte_valid;
        logic [CNT_W-1:0]  read_count;
        logic              last;
    } t_result;

endpackage

// File: src/brb_ram.sv
`timescale 1ns / 1ps
// brb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/brb_front.sv
`timescale 1ns / 1ps
// brb_front: accepts input transactions, classifies them into commands and
// holds them in a two-entry queue for the back end. Depends on brb_pkg.
module brb_front #(
    parameter int READ_MAX = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_opcode,
    input  logic [brb_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic signed [brb_pkg::OFF_W-1:0] i_offset,
    input  logic [brb_pkg::LEN_W-1:0]       i_length,
    input  logic                            i_burst_first,
    output logic                            o_cmd_valid,
    output brb_pkg::t_cmd                   o_cmd,
    input  logic                            i_cmd_pop
);
    import brb_pkg::*;

    t_cmd       n_cmd;
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;

    // Saturate the read request at READ_MAX here, so the back end sees a narrow count
    always_comb begin
        n_cmd.op       = t_op'(i_opcode);
        n_cmd.data     = i_data_byte;
        n_cmd.offset   = i_offset;
        n_cmd.length   = i_length;
        n_cmd.first    = i_burst_first;
        n_cmd.read_len = (i_length > LEN_W'(READ_MAX)) ? CNT_W'(READ_MAX)
                                                        : i_length[CNT_W-1:0];
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];
    assign n_cnt       = r_cnt + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

// File: src/brb_back.sv
`timescale 1ns / 1ps
// brb_back: executes commands against the pointers and the byte store, and
// queues results in a two-entry output queue. Depends on brb_pkg and brb_ram.
module brb_back #(
    parameter int DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  brb_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output brb_pkg::t_result   o_result
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int OW = (AW > OFF_W) ? AW : OFF_W;

    t_back_state r_state, n_state;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_wp, n_wp;
    logic [LEN_W-1:0] r_brem, n_brem;
    logic             r_brej, n_brej;
    logic [CNT_W-1:0] r_rrem, n_rrem;
    logic [CNT_W-1:0] r_rd_n, n_rd_n;
    logic             r_pend, n_pend;
    logic             r_pend_last, n_pend_last;

    t_result    r_oq [2];
    logic       r_owp;
    logic       r_orp;
    logic [1:0] r_ocnt;

    logic [PW-1:0]          fill;
    logic                   full;
    logic                   out_pop;
    logic                   credit;
    logic                   go_idle;
    logic [CNT_W-1:0]       rd_n;
    logic                   burst_over;
    logic [PW-1:0]          rep_base;
    logic signed [OW-1:0]   off_ext;
    logic [OW-1:0]          rep_sum;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic    imm_push;
    t_result imm_res;
    logic    res_push;
    t_result res_in;

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Pointers run modulo 2*DEPTH, so the wrapped difference is the fill level
    assign fill       = r_wp - r_rp;
    assign full       = (fill == PW'(DEPTH));
    assign rd_n       = (CW'(fill) < CW'(i_cmd.read_len)) ? CNT_W'(fill) : i_cmd.read_len;
    assign burst_over = (CW'(fill) + CW'(i_cmd.length)) > CW'(DEPTH);

    // Replace position: negative offsets count back from the write pointer
    assign rep_base = i_cmd.offset[OFF_W-1] ? r_wp : r_rp;
    assign off_ext  = OW'(i_cmd.offset);
    assign rep_sum  = OW'(rep_base[AW-1:0]) + off_ext;

    // Credit: output queue entries plus a byte in flight from the store
    assign out_pop = o_valid && !i_stall;
    assign credit  = ({1'b0, r_ocnt} + {2'b00, r_pend}) < (3'd2 + {2'b00, out_pop});
    assign go_idle = (r_state == BK_IDLE) && i_cmd_valid && credit && !r_pend;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (go_idle && (i_cmd.op == OP_READ) && (rd_n > CNT_W'(1))) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (credit && (r_rrem == CNT_W'(1))) begin
                    n_state = BK_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_wp[AW-1:0];
        ram_wdata   = i_cmd.data;
        ram_re      = 1'b0;
        ram_raddr   = r_rp[AW-1:0];
        imm_push    = 1'b0;
        imm_res     = '0;
        imm_res.last = 1'b1;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_brem      = r_brem;
        n_brej      = r_brej;
        n_rrem      = r_rrem;
        n_rd_n      = r_rd_n;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        unique case (r_state)
            BK_IDLE: begin
                if (go_idle) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_PUT: begin
                            imm_push       = 1'b1;
                            imm_res.status = full;
                            if (!full) begin
                                ram_we = 1'b1;
                                n_wp   = r_wp + PW'(1);
                            end
                        end
                        OP_REPLACE: begin
                            imm_push  = 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = rep_sum[AW-1:0];
                        end
                        OP_BURST: begin
                            imm_push = 1'b1;
                            if (i_cmd.first) begin
                                if (burst_over) begin
                                    // reject the whole burst, swallow the rest of it
                                    n_brej         = 1'b1;
                                    n_brem         = (i_cmd.length != '0)
                                                     ? i_cmd.length - LEN_W'(1) : '0;
                                    imm_res.status = 1'b1;
                                end else begin
                                    n_brej = 1'b0;
                                    if (i_cmd.length == '0) begin
                                        n_brem = '0;
                                    end else begin
                                        n_brem         = i_cmd.length - LEN_W'(1);
                                        imm_res.status = full;
                                        if (!full) begin
                                            ram_we = 1'b1;
                                            n_wp   = r_wp + PW'(1);
                                        end
                                    end
                                end
                            end else if (r_brem == '0) begin
                                imm_res.status = 1'b1;
                            end else begin
                                n_brem = r_brem - LEN_W'(1);
                                if (r_brej) begin
                                    imm_res.status = 1'b1;
                                end else begin
                                    imm_res.status = full;
                                    if (!full) begin
                                        ram_we = 1'b1;
                                        n_wp   = r_wp + PW'(1);
                                    end
                                end
                            end
                        end
                        OP_READ: begin
                            if (rd_n == '0) begin
                                imm_push = 1'b1;
                            end else begin
                                ram_re      = 1'b1;
                                n_rp        = r_rp + PW'(1);
                                n_pend      = 1'b1;
                                n_pend_last = (rd_n == CNT_W'(1));
                                n_rd_n      = rd_n;
                                n_rrem      = rd_n - CNT_W'(1);
                            end
                        end
                    endcase
                end
            end
            BK_READ: begin
                if (credit) begin
                    ram_re      = 1'b1;
                    n_rp        = r_rp + PW'(1);
                    n_pend      = 1'b1;
                    n_pend_last = (r_rrem == CNT_W'(1));
                    n_rrem      = r_rrem - CNT_W'(1);
                end
            end
        endcase
    end

    // A byte in flight and an immediate result never coincide
    always_comb begin
        res_push = r_pend || imm_push;
        if (r_pend) begin
            res_in.status     = 1'b0;
            res_in.read_byte  = ram_rdata;
            res_in.byte_valid = 1'b1;
            res_in.read_count = r_rd_n;
            res_in.last       = r_pend_last;
        end else begin
            res_in = imm_res;
        end
    end

    assign o_valid  = (r_ocnt != 2'd0);
    assign o_result = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_brem      <= '0;
            r_brej      <= 1'b0;
            r_rrem      <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_owp       <= 1'b0;
            r_orp       <= 1'b0;
            r_ocnt      <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_brem      <= n_brem;
            r_brej      <= n_brej;
            r_rrem      <= n_rrem;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            if (res_push) begin
                r_owp <= !r_owp;
            end
            if (out_pop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, res_push} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_n <= n_rd_n;
        if (res_push) begin
            r_oq[r_owp] <= res_in;
        end
    end

endmodule

// File: src/byte_ring_buffer.sv
`timescale 1ns / 1ps
// byte_ring_buffer: top level of the byte FIFO with put, replace, burst write
// and run reads. Depends on brb_pkg, brb_front, brb_back and brb_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_stall  | opcode, data_byte, offset, length, first
//  result  | out       | o_valid / i_stall  | status, read_byte, byte_valid, count, last
//
// A put, replace or burst byte is executed as soon as the back end takes it; a read
// fetches its first byte as the command is taken, then each further byte in turn,
// paced by the single read port of the store and the two-entry output queue.
// A command following a read waits for the last byte to leave the store.
// Reset is synchronous and active low; it clears pointers, burst state and queues.
// The byte store is not cleared. Either side may stall without blocking the other
// until the two-entry command queue or output queue fills.
// DEPTH must be a power of two.
module byte_ring_buffer #(
    parameter int DEPTH    = 1024,
    parameter int READ_MAX = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_opcode,
    input  logic [brb_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic signed [brb_pkg::OFF_W-1:0] i_offset,
    input  logic [brb_pkg::LEN_W-1:0]        i_length,
    input  logic                             i_burst_first,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_status,
    output logic [brb_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                             o_byte_valid,
    output logic [brb_pkg::CNT_W-1:0]        o_read_count,
    output logic                             o_last
);
    import brb_pkg::*;

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    t_result result;

    // Front: take the transaction, saturate the read count, queue the command
    brb_front #(
        .READ_MAX (READ_MAX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .i_offset      (i_offset),
        .i_length      (i_length),
        .i_burst_first (i_burst_first),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    // Back: own the pointers and the store, drain reads as a run of results
    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (result)
    );

    assign o_status     = result.status;
    assign o_read_byte  = result.read_byte;
    assign o_byte_valid = result.byte_valid;
    assign o_read_count = result.read_count;
    assign o_last       = result.last;

`ifndef SYNTHESIS
    // A popped byte always belongs to an accepted read of at least one byte
    a_byte_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> ((o_read_count != '0) && !o_status))
        else $error("popped byte without a read count");

    // Any result carrying no byte is the single, final result of its transaction
    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_last && (o_read_count == '0)))
        else $error("result without byte is not a lone final result");

    // The reported run length never exceeds the read limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> (o_read_count <= CNT_W'(READ_MAX)))
        else $error("read count above the read limit");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for byte_ring_buffer (put, replace, burst write, run reads).
// Depends on brb_pkg for the opcode and result types, and on the byte_ring_buffer RTL.
module tb;
    import brb_pkg::*;

    localparam int RING_DEPTH = 1024;
    localparam int READ_LIMIT = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int RANDOM_OPS = 305;

    typedef struct {
        t_op                     op;
        logic [BYTE_W-1:0]       data;
        logic signed [OFF_W-1:0] offset;
        logic [LEN_W-1:0]        length;
        logic                    first;
    } t_ring_cmd;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_valid       = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_opcode      = OP_PUT;
    logic [BYTE_W-1:0]        i_data_byte   = '0;
    logic signed [OFF_W-1:0]  i_offset      = '0;
    logic [LEN_W-1:0]         i_length      = '0;
    logic                     i_burst_first = 1'b0;
    logic                     o_valid;
    logic                     i_stall       = 1'b0;
    logic                     o_status;
    logic [BYTE_W-1:0]        o_read_byte;
    logic                     o_byte_valid;
    logic [CNT_W-1:0]         o_read_count;
    logic                     o_last;

    byte_ring_buffer #(
        .DEPTH    (RING_DEPTH),
        .READ_MAX (READ_LIMIT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .i_offset      (i_offset),
        .i_length      (i_length),
        .i_burst_first (i_burst_first),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_read_byte   (o_read_byte),
        .o_byte_valid  (o_byte_valid),
        .o_read_count  (o_read_count),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Commands waiting to be offered, and results owed by the block in order
    t_ring_cmd pending_cmds[$];
    t_result   owed_results[$];

    int fails        = 0;
    int results_seen = 0;

    // ------------------------------------------------------------------
    // Shadow of the ring: store, free-running pointers modulo 2*DEPTH,
    // and the state of the burst that is open, if any
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [IDX_W:0]    ring_rd      = '0;
    logic [IDX_W:0]    ring_wr      = '0;
    logic [LEN_W-1:0]  burst_left   = '0;
    logic              burst_bad    = 1'b0;

    // Append one byte; a set return means the ring was full and the byte is dropped
    function automatic logic ring_push(input logic [BYTE_W-1:0] b);
        logic [IDX_W:0] lvl;
        lvl = ring_wr - ring_rd;
        if (lvl >= RING_DEPTH) begin
            return 1'b1;
        end
        ring_mem[ring_wr[IDX_W-1:0]] = b;
        ring_wr = ring_wr + 1'b1;
        return 1'b0;
    endfunction

    // Work out the results one accepted transaction owes and queue them
    function automatic void ring_predict(input t_ring_cmd c);
        t_result        r;
        logic [IDX_W:0] lvl;
        logic [IDX_W:0] pos;
        int             n;
        r      = '0;
        r.last = 1'b1;
        lvl    = ring_wr - ring_rd;
        case (c.op)
            OP_PUT: begin
                r.status = ring_push(c.data);
            end
            OP_REPLACE: begin
                // negative offsets count back from the write pointer
                pos = (c.offset[OFF_W-1] ? ring_wr : ring_rd) + c.offset;
                ring_mem[pos[IDX_W-1:0]] = c.data;
            end
            OP_BURST: begin
                if (c.first) begin
                    burst_left = (c.length != 0) ? c.length - 1'b1 : '0;
                    if (int'(lvl) + int'(c.length) > RING_DEPTH) begin
                        burst_bad = 1'b1;
                        r.status  = 1'b1;
                    end else begin
                        burst_bad = 1'b0;
                        if (c.length != 0) begin
                            r.status = ring_push(c.data);
                        end
                    end
                end else if (burst_left == 0) begin
                    r.status = 1'b1;
                end else begin
                    burst_left = burst_left - 1'b1;
                    r.status   = burst_bad ? 1'b1 : ring_push(c.data);
                end
            end
            default: begin
                n = c.length;
                if (n > READ_LIMIT) n = READ_LIMIT;
                if (n > int'(lvl)) n = lvl;
                if (n != 0) begin
                    for (int i = 0; i < n; i++) begin
                        r.read_byte  = ring_mem[ring_rd[IDX_W-1:0]];
                        r.byte_valid = 1'b1;
                        r.read_count = CNT_W'(n);
                        r.last       = (i == n - 1);
                        ring_rd      = ring_rd + 1'b1;
                        owed_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        owed_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus planning. A rough fill tracker steers burst lengths onto
    // the fit/no-fit boundary; it does not take part in checking.
    // ------------------------------------------------------------------
    int plan_fill = 0;
    int plan_left = 0;
    bit plan_bad  = 0;
    int planned   = 0;

    task automatic plan_cmd(input t_op op, input int d, input int off, input int len,
                            input bit first);
        t_ring_cmd c;
        int        n;
        c.op     = op;
        c.data   = BYTE_W'(d);
        c.offset = OFF_W'(off);
        c.length = LEN_W'(len);
        c.first  = first;
        pending_cmds.push_back(c);
        planned++;
        case (op)
            OP_PUT: begin
                if (plan_fill < RING_DEPTH) plan_fill++;
            end
            OP_BURST: begin
                if (first) begin
                    plan_left = (len > 0) ? len - 1 : 0;
                    plan_bad  = (plan_fill + len > RING_DEPTH);
                    if (!plan_bad && len > 0 && plan_fill < RING_DEPTH) plan_fill++;
                end else if (plan_left > 0) begin
                    plan_left--;
                    if (!plan_bad && plan_fill < RING_DEPTH) plan_fill++;
                end
            end
            OP_READ: begin
                n = (len > READ_LIMIT) ? READ_LIMIT : len;
                plan_fill -= (n > plan_fill) ? plan_fill : n;
            end
            default: ;
        endcase
    endtask

    function automatic int any_byte();
        return $urandom_range(0, 255);
    endfunction

    function automatic int any_len();
        return $urandom_range(0, 1024);
    endfunction

    // One well-formed burst with random content, sometimes cut short or
    // interleaved with puts and reads
    task automatic plan_burst();
        int len;
        int n_cont;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            len = 0;
        end else if (pick == 1) begin
            len = RING_DEPTH - plan_fill;
        end else if (pick == 2) begin
            len = RING_DEPTH - plan_fill + 1;
            if (len > RING_DEPTH) len = RING_DEPTH;
        end else begin
            len = $urandom_range(1, 10);
        end
        plan_cmd(OP_BURST, any_byte(), $urandom_range(0, 2047), len, 1'b1);
        n_cont = (len > 0) ? len - 1 : 0;
        if (n_cont > 10) n_cont = 10;
        if ($urandom_range(0, 9) == 0) n_cont = $urandom_range(0, n_cont);
        for (int i = 0; i < n_cont; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) != 0) begin
                    plan_cmd(OP_PUT, any_byte(), $urandom_range(0, 2047), any_len(),
                             $urandom_range(0, 1));
                end else begin
                    plan_cmd(OP_READ, any_byte(), $urandom_range(0, 2047),
                             $urandom_range(0, 8), 1'b0);
                end
            end
            plan_cmd(OP_BURST, any_byte(), $urandom_range(0, 2047), any_len(), 1'b0);
        end
    endtask

    task automatic plan_random();
        int pick;
        int off;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            plan_burst();
        end else if (pick < 60) begin
            repeat ($urandom_range(1, 6)) begin
                plan_cmd(OP_PUT, any_byte(), $urandom_range(0, 2047), any_len(),
                         $urandom_range(0, 1));
            end
        end else if (pick < 80) begin
            plan_cmd(OP_READ, any_byte(), $urandom_range(0, 2047),
                     ($urandom_range(0, 3) == 0) ? any_len() : $urandom_range(0, 70),
                     $urandom_range(0, 1));
        end else if (pick < 90) begin
            // mostly near the live region, sometimes anywhere in offset range
            off = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(0, 16) - 8;
            plan_cmd(OP_REPLACE, any_byte(), off, any_len(), $urandom_range(0, 1));
        end else begin
            // noise: fully random fields, stray continuations included
            plan_cmd(t_op'($urandom_range(0, 3)), any_byte(), $urandom_range(0, 2047),
                     any_len(), $urandom_range(0, 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions separated by random gaps. A held
    // transaction never changes while the block stalls it.
    // ------------------------------------------------------------------
    int send_run = 0;
    int send_gap = 0;

    task automatic offer_next();
        t_ring_cmd c;
        c = pending_cmds.pop_front();
        i_opcode      <= c.op;
        i_data_byte   <= c.data;
        i_offset      <= c.offset;
        i_length      <= c.length;
        i_burst_first <= c.first;
        i_valid       <= 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_ring_cmd took;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                took.op     = t_op'(i_opcode);
                took.data   = i_data_byte;
                took.offset = i_offset;
                took.length = i_length;
                took.first  = i_burst_first;
                ring_predict(took);
                if (send_run > 0 && pending_cmds.size() != 0) begin
                    send_run--;
                    offer_next();
                end else begin
                    i_valid  <= 1'b0;
                    send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else if (!i_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_cmds.size() != 0) begin
                    send_run = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 23);
                    offer_next();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall probability changes from phase to phase, with two
    // long hold-offs so that the block fills up and stalls its input
    // ------------------------------------------------------------------
    int stall_pct    = 0;
    int pattern_left = 0;
    int hold_left    = 0;
    int holds_done   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    2:       stall_pct = 70;
                    default: stall_pct = 95;
                endcase
                pattern_left = $urandom_range(32, 200);
            end else begin
                pattern_left--;
            end
            if ((holds_done == 0 && results_seen >= 120) ||
                (holds_done == 1 && results_seen >= 300)) begin
                holds_done++;
                hold_left = 400;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each delivered result with the oldest one owed
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (owed_results.size() == 0) begin
                $error("result with none owed: status %0d byte %0d valid %0d count %0d last %0d",
                       o_status, o_read_byte, o_byte_valid, o_read_count, o_last);
                fails++;
            end else begin
                want = owed_results.pop_front();
                check_field("status",     want.status,     o_status);
                check_field("read_byte",  want.read_byte,  o_read_byte);
                check_field("byte_valid", want.byte_valid, o_byte_valid);
                check_field("read_count", want.read_count, o_read_count);
                check_field("last",       want.last,       o_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: plan everything, release reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        int target;

        // Directed: empty read, byte extremes, replace at both offset ends,
        // stray continuation, empty burst, rejected and abandoned bursts,
        // read saturation and an exact-fit burst of full depth
        plan_cmd(OP_READ,    8'h00, 0,     5,    1'b1);
        plan_cmd(OP_PUT,     8'h00, 0,     0,    1'b0);
        plan_cmd(OP_PUT,     8'hFF, 0,     1024, 1'b1);
        plan_cmd(OP_PUT,     8'h5A, 0,     0,    1'b0);
        plan_cmd(OP_REPLACE, 8'h11, 0,     0,    1'b0);
        plan_cmd(OP_REPLACE, 8'h22, -1,    0,    1'b0);
        plan_cmd(OP_REPLACE, 8'h33, 1023,  0,    1'b1);
        plan_cmd(OP_REPLACE, 8'h44, -1024, 0,    1'b0);
        plan_cmd(OP_BURST,   8'h99, 0,     3,    1'b0);
        plan_cmd(OP_BURST,   8'h98, 0,     0,    1'b1);
        plan_cmd(OP_BURST,   8'hC3, 0,     2,    1'b1);
        plan_cmd(OP_BURST,   8'h3C, 0,     0,    1'b0);
        plan_cmd(OP_BURST,   8'h77, 0,     0,    1'b0);
        plan_cmd(OP_BURST,   8'hE1, 0,     1024, 1'b1);
        plan_cmd(OP_BURST,   8'hE2, 0,     0,    1'b0);
        plan_cmd(OP_BURST,   8'h7E, 0,     3,    1'b1);
        plan_cmd(OP_BURST,   8'h81, 0,     0,    1'b0);
        plan_cmd(OP_READ,    8'hFF, -1,    1,    1'b0);
        plan_cmd(OP_READ,    8'h00, 0,     1024, 1'b0);
        plan_cmd(OP_READ,    8'h00, 0,     0,    1'b0);
        plan_cmd(OP_BURST,   8'hA0, 0,     1024, 1'b1);
        plan_cmd(OP_BURST,   8'hA1, 0,     0,    1'b0);
        plan_cmd(OP_BURST,   8'hA2, 0,     0,    1'b0);
        plan_cmd(OP_READ,    8'h00, 0,     2,    1'b0);
        plan_cmd(OP_READ,    8'h00, 0,     1024, 1'b0);

        target = planned + RANDOM_OPS;
        while (planned < target) begin
            plan_random();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_valid) @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
        // let any stray result surface before judging
        repeat (40) @(posedge i_clk);

        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
